### src/abp_pkg.sv
// ----------------------------------------------------------------------------
// abp_pkg
// shared types, constants and saturating helpers of the basis pursuit solver
// ----------------------------------------------------------------------------
package abp_pkg;

  localparam int MAX_DIM_DEF   = 64;
  localparam int TILE_ROWS_DEF = 16;

  // counters over n, which never exceeds 64
  localparam int CNT_W = 7;
  localparam int CAP_N = 64;

  localparam logic [1:0] REQ_LOAD_P = 2'd0;
  localparam logic [1:0] REQ_LOAD_V = 2'd1;
  localparam logic [1:0] REQ_START  = 2'd2;

  localparam logic [2:0] REG_RHO   = 3'd0;
  localparam logic [2:0] REG_ALPHA = 3'd1;
  localparam logic [2:0] REG_LEN   = 3'd2;
  localparam logic [2:0] REG_CHK   = 3'd3;
  localparam logic [2:0] REG_LIMIT = 3'd4;
  localparam logic [2:0] REG_ATOL  = 3'd5;
  localparam logic [2:0] REG_RTOL  = 3'd6;

  localparam logic [30:0] RHO_RST   = 31'd65536;
  localparam logic [17:0] ALPHA_RST = 18'd65536;
  localparam logic [6:0]  LEN_RST   = 7'd64;
  localparam logic [30:0] ATOL_RST  = 31'd7;
  localparam logic [30:0] RTOL_RST  = 31'd655;

  localparam logic signed [19:0] FX_ONE = 20'sd65536;
  localparam logic signed [31:0] S32_MAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] S32_MIN = -32'sh80000000;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [5:0]         row;
    logic [5:0]         col;
    logic signed [31:0] p_value;
    logic signed [31:0] q_value;
    logic signed [31:0] z_init;
    logic signed [31:0] u_init;
    logic signed [31:0] zold_init;
  } in_word_t;

  typedef struct packed {
    logic [5:0]         index;
    logic signed [31:0] x_result;
    logic signed [31:0] z_result;
    logic signed [31:0] u_result;
    logic signed [31:0] zold_result;
    logic [15:0]        iterations_done;
    logic               converged;
    logic [30:0]        primal_residual;
    logic [30:0]        dual_residual;
    logic               last;
  } out_word_t;

  typedef struct packed {
    logic signed [31:0] q;
    logic signed [31:0] z;
    logic signed [31:0] u;
    logic signed [31:0] zold;
    logic signed [31:0] x;
  } vec_word_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'(S32_MAX)) return S32_MAX;
    if (v < 64'(S32_MIN)) return S32_MIN;
    return 32'(v);
  endfunction

  function automatic logic [63:0] sat_addu(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  function automatic logic [30:0] sat31(input logic [31:0] v);
    return v[31] ? '1 : v[30:0];
  endfunction

endpackage

### src/admm_basis_pursuit_solver_top.sv
// ----------------------------------------------------------------------------
// admm_basis_pursuit_solver_top
// fixed-point ADMM basis pursuit solver around a matrix memory and a vector
// memory, with a serial square root unit and a serial reciprocal unit
//
//   port group   dir   handshake            word
//   in_          in    in_valid / in_stall  in_word_t   (load or start)
//   out_         out   out_valid/out_stall  out_word_t  (one per element)
//   apb          in    psel/penable/pready  32-bit registers at 4*i
//
// a start first computes the threshold, then runs each iteration tile by tile,
// in tiles of up to TILE_ROWS rows, then the norm test when it is on; the
// results then go out one element at a time
// in_stall is high from start until the last result is taken
// stores are not cleared at reset; sync active-low reset clears control only
// ----------------------------------------------------------------------------
module admm_basis_pursuit_solver_top #(
  parameter int MAX_DIM   = abp_pkg::MAX_DIM_DEF,
  parameter int TILE_ROWS = abp_pkg::TILE_ROWS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  abp_pkg::in_word_t   in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output abp_pkg::out_word_t  out_word,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import abp_pkg::*;

  localparam int VW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int MW = $clog2(MAX_DIM * MAX_DIM);
  localparam int TW = (TILE_ROWS > 1) ? $clog2(TILE_ROWS) : 1;

  localparam logic [4:0] S_IDLE      = 5'd0;
  localparam logic [4:0] S_KGO       = 5'd1;
  localparam logic [4:0] S_KWAIT     = 5'd2;
  localparam logic [4:0] S_ITER      = 5'd3;
  localparam logic [4:0] S_TILE      = 5'd4;
  localparam logic [4:0] S_DOT       = 5'd5;
  localparam logic [4:0] S_DRAIN     = 5'd6;
  localparam logic [4:0] S_WB_RD     = 5'd7;
  localparam logic [4:0] S_WB_X      = 5'd8;
  localparam logic [4:0] S_WB_MUL    = 5'd9;
  localparam logic [4:0] S_WB_XH     = 5'd10;
  localparam logic [4:0] S_WB_Z      = 5'd11;
  localparam logic [4:0] S_WB_WR     = 5'd12;
  localparam logic [4:0] S_ITER_END  = 5'd13;
  localparam logic [4:0] S_CHK       = 5'd14;
  localparam logic [4:0] S_CHK_DRAIN = 5'd15;
  localparam logic [4:0] S_SQ_GO     = 5'd16;
  localparam logic [4:0] S_SQ_WAIT   = 5'd17;
  localparam logic [4:0] S_EPS1      = 5'd18;
  localparam logic [4:0] S_EPS2      = 5'd19;
  localparam logic [4:0] S_EPS3      = 5'd20;
  localparam logic [4:0] S_EPS4      = 5'd21;
  localparam logic [4:0] S_OUT_RD    = 5'd22;
  localparam logic [4:0] S_OUT_LD    = 5'd23;
  localparam logic [4:0] S_OUT_HOLD  = 5'd24;

  function automatic logic signed [31:0] shrink(input logic signed [31:0] v,
                                                input logic signed [31:0] k);
    logic signed [63:0] vv;
    logic signed [63:0] kk;
    vv = 64'(v);
    kk = 64'(k);
    if (vv > kk) return sat32(vv - kk);
    if (vv < -kk) return sat32(vv + kk);
    return '0;
  endfunction

  // configuration registers
  logic [30:0] cfg_rho_r;
  logic [17:0] cfg_alpha_r;
  logic [6:0]  cfg_len_r;
  logic        cfg_chk_r;
  logic [15:0] cfg_limit_r;
  logic [30:0] cfg_atol_r;
  logic [30:0] cfg_rtol_r;
  logic        cfg_we;
  logic [2:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_rho_r   <= RHO_RST;
      cfg_alpha_r <= ALPHA_RST;
      cfg_len_r   <= LEN_RST;
      cfg_chk_r   <= 1'b0;
      cfg_limit_r <= '0;
      cfg_atol_r  <= ATOL_RST;
      cfg_rtol_r  <= RTOL_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_RHO:   cfg_rho_r   <= pwdata[30:0];
        REG_ALPHA: cfg_alpha_r <= pwdata[17:0];
        REG_LEN:   cfg_len_r   <= pwdata[6:0];
        REG_CHK:   cfg_chk_r   <= pwdata[0];
        REG_LIMIT: cfg_limit_r <= pwdata[15:0];
        REG_ATOL:  cfg_atol_r  <= pwdata[30:0];
        REG_RTOL:  cfg_rtol_r  <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_RHO:   prdata = {1'b0, cfg_rho_r};
      REG_ALPHA: prdata = {14'd0, cfg_alpha_r};
      REG_LEN:   prdata = {25'd0, cfg_len_r};
      REG_CHK:   prdata = {31'd0, cfg_chk_r};
      REG_LIMIT: prdata = {16'd0, cfg_limit_r};
      REG_ATOL:  prdata = {1'b0, cfg_atol_r};
      REG_RTOL:  prdata = {1'b0, cfg_rtol_r};
      default:   prdata = '0;
    endcase
  end

  // control state
  logic [4:0]       state_r;
  logic [CNT_W-1:0] col_r;
  logic [TW-1:0]    ri_r;
  logic [TW-1:0]    tile_last_r;
  logic [CNT_W-1:0] tile_off_r;
  logic [CNT_W-1:0] seg_end_r;
  logic             seg_r;
  logic [MW-1:0]    row_base_r;
  logic [15:0]      iter_cnt_r;
  logic             conv_r;
  logic [2:0]       sq_sel_r;
  logic [CNT_W-1:0] n_r;

  logic in_acc;
  logic start_ok;
  logic [CNT_W-1:0] tile_rem;
  logic [CNT_W-1:0] wb_row;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign start_ok = (cfg_len_r != '0) && (32'(cfg_len_r) <= MAX_DIM) &&
                    (32'(cfg_len_r) <= CAP_N);
  assign tile_rem = seg_end_r - tile_off_r;
  assign wb_row   = tile_off_r + CNT_W'(ri_r);

  // memories
  logic signed [31:0] mmem [MAX_DIM*MAX_DIM];
  vec_word_t          vmem [MAX_DIM];
  logic signed [31:0] mat_rd_r;
  vec_word_t          vec_rd_r;
  logic               m_we;
  logic [MW-1:0]      m_waddr;
  logic [MW-1:0]      m_raddr;
  logic               v_we;
  logic [VW-1:0]      v_waddr;
  logic [VW-1:0]      v_raddr;
  vec_word_t          v_wdata;
  vec_word_t          wb_word;
  logic               ld_v;

  assign m_we    = in_acc && (in_word.req_type == REQ_LOAD_P) &&
                   (32'(in_word.row) < MAX_DIM) && (32'(in_word.col) < MAX_DIM);
  assign m_waddr = MW'(in_word.row) * MW'(MAX_DIM) + MW'(in_word.col);
  assign m_raddr = row_base_r + MW'(col_r);
  assign ld_v    = in_acc && (in_word.req_type == REQ_LOAD_V) &&
                   (32'(in_word.row) < MAX_DIM);
  assign v_we    = ld_v || (state_r == S_WB_WR);
  assign v_waddr = ld_v ? VW'(in_word.row) : VW'(wb_row);
  assign v_raddr = (state_r == S_WB_RD) ? VW'(wb_row) : VW'(col_r);
  assign v_wdata = ld_v ? '{q: in_word.q_value, z: in_word.z_init, u: in_word.u_init,
                            zold: in_word.zold_init, x: '0} : wb_word;

  always_ff @(posedge clk) begin
    if (m_we) mmem[m_waddr] <= in_word.p_value;
    mat_rd_r <= mmem[m_raddr];
  end

  always_ff @(posedge clk) begin
    if (v_we) vmem[v_waddr] <= v_wdata;
    vec_rd_r <= vmem[v_raddr];
  end

  // serial units
  logic               k_start;
  logic               k_done;
  logic signed [31:0] k_val;
  logic signed [31:0] kappa_r;
  logic               sq_start;
  logic               sq_done;
  logic [63:0]        sq_op;
  logic [31:0]        sq_root;

  assign k_start  = (state_r == S_KGO);
  assign sq_start = (state_r == S_SQ_GO);

  abp_recip u_recip (
    .clk(clk), .rst_n(rst_n), .start(k_start), .divisor(cfg_rho_r),
    .done(k_done), .kappa(k_val)
  );

  abp_isqrt u_isqrt (
    .clk(clk), .rst_n(rst_n), .start(sq_start), .operand(sq_op),
    .done(sq_done), .root(sq_root)
  );

  // dot product pipeline
  logic               iss_v_r, iss_first_r, iss_last_r;
  logic [TW-1:0]      iss_ri_r;
  logic               s1_v_r, s1_first_r, s1_last_r;
  logic [TW-1:0]      s1_ri_r;
  logic signed [31:0] s1_p_r, s1_zu_r;
  logic               s2_v_r, s2_first_r, s2_last_r;
  logic [TW-1:0]      s2_ri_r;
  logic signed [63:0] s2_prod_r;
  logic signed [31:0] acc_r;
  logic signed [31:0] acc_buf [TILE_ROWS];
  logic signed [31:0] acc_sum;
  logic signed [31:0] dot_term;

  assign dot_term = sat32(s2_prod_r >>> 16);
  assign acc_sum  = sat32(64'(s2_first_r ? 32'sd0 : acc_r) + 64'(dot_term));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_v_r <= 1'b0;
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
    end else begin
      iss_v_r     <= (state_r == S_DOT);
      iss_first_r <= (col_r == '0);
      iss_last_r  <= (col_r == n_r - CNT_W'(1));
      iss_ri_r    <= ri_r;
      s1_v_r      <= iss_v_r;
      s1_first_r  <= iss_first_r;
      s1_last_r   <= iss_last_r;
      s1_ri_r     <= iss_ri_r;
      s1_p_r      <= mat_rd_r;
      s1_zu_r     <= sat32(64'(vec_rd_r.z) - 64'(vec_rd_r.u));
      s2_v_r      <= s1_v_r;
      s2_first_r  <= s1_first_r;
      s2_last_r   <= s1_last_r;
      s2_ri_r     <= s1_ri_r;
      s2_prod_r   <= 64'(s1_p_r) * 64'(s1_zu_r);
      if (s2_v_r) begin
        acc_r <= acc_sum;
        if (s2_last_r) acc_buf[s2_ri_r] <= acc_sum;
      end
    end
  end

  // norm pipeline
  logic               ck0_v_r, ck1_v_r, ck2_v_r, ck3_v_r, ck4_v_r;
  logic signed [31:0] ck1_dz_r, ck1_pe_r, ck1_x_r, ck1_z_r, ck1_u_r;
  logic signed [63:0] ck2_rp_r;
  logic signed [31:0] ck2_pe_r, ck2_x_r, ck2_z_r, ck2_u_r;
  logic signed [31:0] ck3_de_r, ck3_pe_r, ck3_x_r, ck3_z_r, ck3_u_r;
  logic [63:0]        ck4_rs_r, ck4_ss_r, ck4_xs_r, ck4_zs_r, ck4_us_r;
  logic [63:0]        sum_rs_r, sum_ss_r, sum_xs_r, sum_zs_r, sum_us_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ck0_v_r <= 1'b0;
      ck1_v_r <= 1'b0;
      ck2_v_r <= 1'b0;
      ck3_v_r <= 1'b0;
      ck4_v_r <= 1'b0;
    end else begin
      ck0_v_r  <= (state_r == S_CHK);
      ck1_v_r  <= ck0_v_r;
      ck1_dz_r <= sat32(64'(vec_rd_r.z) - 64'(vec_rd_r.zold));
      ck1_pe_r <= sat32(64'(vec_rd_r.x) - 64'(vec_rd_r.z));
      ck1_x_r  <= vec_rd_r.x;
      ck1_z_r  <= vec_rd_r.z;
      ck1_u_r  <= vec_rd_r.u;
      ck2_v_r  <= ck1_v_r;
      ck2_rp_r <= 64'($signed({1'b0, cfg_rho_r})) * 64'(ck1_dz_r);
      ck2_pe_r <= ck1_pe_r;
      ck2_x_r  <= ck1_x_r;
      ck2_z_r  <= ck1_z_r;
      ck2_u_r  <= ck1_u_r;
      ck3_v_r  <= ck2_v_r;
      ck3_de_r <= sat32(ck2_rp_r >>> 16);
      ck3_pe_r <= ck2_pe_r;
      ck3_x_r  <= ck2_x_r;
      ck3_z_r  <= ck2_z_r;
      ck3_u_r  <= ck2_u_r;
      ck4_v_r  <= ck3_v_r;
      ck4_rs_r <= 64'(64'(ck3_pe_r) * 64'(ck3_pe_r));
      ck4_ss_r <= 64'(64'(ck3_de_r) * 64'(ck3_de_r));
      ck4_xs_r <= 64'(64'(ck3_x_r) * 64'(ck3_x_r));
      ck4_zs_r <= 64'(64'(ck3_z_r) * 64'(ck3_z_r));
      ck4_us_r <= 64'(64'(ck3_u_r) * 64'(ck3_u_r));
    end
  end

  always_comb begin
    case (sq_sel_r)
      3'd0:    sq_op = sum_rs_r;
      3'd1:    sq_op = sum_ss_r;
      3'd2:    sq_op = sum_xs_r;
      3'd3:    sq_op = sum_zs_r;
      3'd4:    sq_op = sum_us_r;
      default: sq_op = {25'd0, n_r, 32'd0};
    endcase
  end

  // writeback and tolerance datapath registers
  logic signed [31:0] wb_q_r, wb_x_r, wb_z_r, wb_u_r, wb_xh_r, wb_zn_r;
  logic signed [51:0] wb_pa_r, wb_pb_r;
  logic signed [19:0] alpha_s;
  logic signed [19:0] alpha_c;
  logic signed [31:0] wb_v;
  logic signed [31:0] wb_un;
  logic [31:0]        rn_r, sn_r, xn_r, zn_r, ur_r, sqn_r;
  logic [62:0]        un_p_r, base_p_r, ep_p_r, ed_p_r;
  logic [31:0]        un_r;
  logic [46:0]        base_r;
  logic [47:0]        eps_pri, eps_dual;

  assign alpha_s = $signed({2'b00, cfg_alpha_r});
  assign alpha_c = FX_ONE - alpha_s;
  assign wb_v    = sat32(64'(wb_xh_r) + 64'(wb_u_r));
  assign wb_un   = sat32(64'(wb_u_r) + 64'(wb_xh_r) - 64'(wb_zn_r));
  assign wb_word = '{q: wb_q_r, z: wb_zn_r, u: wb_un, zold: wb_z_r, x: wb_x_r};
  assign eps_pri  = 48'(base_r) + 48'(ep_p_r[62:16]);
  assign eps_dual = 48'(base_r) + 48'(ed_p_r[62:16]);

  // output register
  logic      out_valid_r;
  out_word_t out_word_r;

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      col_r       <= '0;
      ri_r        <= '0;
      iter_cnt_r  <= '0;
      conv_r      <= 1'b0;
      sq_sel_r    <= '0;
      seg_r       <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_acc && (in_word.req_type == REQ_START) && start_ok) begin
            n_r        <= cfg_len_r;
            iter_cnt_r <= '0;
            conv_r     <= 1'b0;
            rn_r       <= '0;
            sn_r       <= '0;
            state_r    <= S_KGO;
          end
        end
        S_KGO: state_r <= S_KWAIT;
        S_KWAIT: begin
          if (k_done) begin
            kappa_r <= k_val;
            col_r   <= '0;
            state_r <= (cfg_limit_r == '0) ? S_OUT_RD : S_ITER;
          end
        end
        S_ITER: begin
          iter_cnt_r <= iter_cnt_r + 16'd1;
          seg_r      <= 1'b0;
          tile_off_r <= '0;
          seg_end_r  <= n_r >> 1;
          state_r    <= S_TILE;
        end
        S_TILE: begin
          if (tile_off_r >= seg_end_r) begin
            if (!seg_r) begin
              seg_r      <= 1'b1;
              tile_off_r <= n_r >> 1;
              seg_end_r  <= n_r;
            end else begin
              state_r <= S_ITER_END;
            end
          end else begin
            tile_last_r <= (32'(tile_rem) > TILE_ROWS) ? TW'(TILE_ROWS - 1)
                                                       : TW'(tile_rem - CNT_W'(1));
            row_base_r  <= MW'(tile_off_r) * MW'(MAX_DIM);
            ri_r        <= '0;
            col_r       <= '0;
            state_r     <= S_DOT;
          end
        end
        S_DOT: begin
          if (col_r == n_r - CNT_W'(1)) begin
            col_r      <= '0;
            row_base_r <= row_base_r + MW'(MAX_DIM);
            if (ri_r == tile_last_r) begin
              state_r <= S_DRAIN;
            end else begin
              ri_r <= ri_r + TW'(1);
            end
          end else begin
            col_r <= col_r + CNT_W'(1);
          end
        end
        S_DRAIN: begin
          if (!iss_v_r && !s1_v_r && !s2_v_r) begin
            ri_r    <= '0;
            state_r <= S_WB_RD;
          end
        end
        S_WB_RD: state_r <= S_WB_X;
        S_WB_X: begin
          wb_x_r  <= sat32(64'(acc_buf[ri_r]) + 64'(vec_rd_r.q));
          wb_q_r  <= vec_rd_r.q;
          wb_z_r  <= vec_rd_r.z;
          wb_u_r  <= vec_rd_r.u;
          state_r <= S_WB_MUL;
        end
        S_WB_MUL: begin
          wb_pa_r <= 52'(alpha_s) * 52'(wb_x_r);
          wb_pb_r <= 52'(alpha_c) * 52'(wb_z_r);
          state_r <= S_WB_XH;
        end
        S_WB_XH: begin
          wb_xh_r <= sat32((64'(wb_pa_r) + 64'(wb_pb_r)) >>> 16);
          state_r <= S_WB_Z;
        end
        S_WB_Z: begin
          wb_zn_r <= shrink(wb_v, kappa_r);
          state_r <= S_WB_WR;
        end
        S_WB_WR: begin
          if (ri_r == tile_last_r) begin
            tile_off_r <= tile_off_r + CNT_W'(tile_last_r) + CNT_W'(1);
            state_r    <= S_TILE;
          end else begin
            ri_r    <= ri_r + TW'(1);
            state_r <= S_WB_RD;
          end
        end
        S_ITER_END: begin
          col_r    <= '0;
          sum_rs_r <= '0;
          sum_ss_r <= '0;
          sum_xs_r <= '0;
          sum_zs_r <= '0;
          sum_us_r <= '0;
          if (cfg_chk_r) begin
            state_r <= S_CHK;
          end else if (iter_cnt_r == cfg_limit_r) begin
            state_r <= S_OUT_RD;
          end else begin
            state_r <= S_ITER;
          end
        end
        S_CHK: begin
          if (col_r == n_r - CNT_W'(1)) begin
            col_r   <= '0;
            state_r <= S_CHK_DRAIN;
          end else begin
            col_r <= col_r + CNT_W'(1);
          end
        end
        S_CHK_DRAIN: begin
          if (!ck0_v_r && !ck1_v_r && !ck2_v_r && !ck3_v_r && !ck4_v_r) begin
            sq_sel_r <= '0;
            state_r  <= S_SQ_GO;
          end
        end
        S_SQ_GO: state_r <= S_SQ_WAIT;
        S_SQ_WAIT: begin
          if (sq_done) begin
            case (sq_sel_r)
              3'd0:    rn_r  <= sq_root;
              3'd1:    sn_r  <= sq_root;
              3'd2:    xn_r  <= sq_root;
              3'd3:    zn_r  <= sq_root;
              3'd4:    ur_r  <= sq_root;
              default: sqn_r <= sq_root;
            endcase
            if (sq_sel_r == 3'd5) begin
              state_r <= S_EPS1;
            end else begin
              sq_sel_r <= sq_sel_r + 3'd1;
              state_r  <= S_SQ_GO;
            end
          end
        end
        S_EPS1: begin
          un_p_r   <= 63'(cfg_rho_r) * 63'(ur_r);
          base_p_r <= 63'(sqn_r) * 63'(cfg_atol_r);
          state_r  <= S_EPS2;
        end
        S_EPS2: begin
          un_r    <= (un_p_r[62:48] != '0) ? '1 : un_p_r[47:16];
          base_r  <= base_p_r[62:16];
          state_r <= S_EPS3;
        end
        S_EPS3: begin
          ep_p_r  <= 63'(cfg_rtol_r) * 63'((xn_r > zn_r) ? xn_r : zn_r);
          ed_p_r  <= 63'(cfg_rtol_r) * 63'(un_r);
          state_r <= S_EPS4;
        end
        S_EPS4: begin
          col_r <= '0;
          if ((48'(rn_r) < eps_pri) && (48'(sn_r) < eps_dual)) begin
            conv_r  <= 1'b1;
            state_r <= S_OUT_RD;
          end else if (iter_cnt_r == cfg_limit_r) begin
            state_r <= S_OUT_RD;
          end else begin
            state_r <= S_ITER;
          end
        end
        S_OUT_RD: state_r <= S_OUT_LD;
        S_OUT_LD: begin
          out_word_r.index           <= 6'(col_r);
          out_word_r.x_result        <= (iter_cnt_r == '0) ? 32'sd0 : vec_rd_r.x;
          out_word_r.z_result        <= vec_rd_r.z;
          out_word_r.u_result        <= vec_rd_r.u;
          out_word_r.zold_result     <= vec_rd_r.zold;
          out_word_r.iterations_done <= iter_cnt_r;
          out_word_r.converged       <= conv_r;
          out_word_r.primal_residual <= sat31(rn_r);
          out_word_r.dual_residual   <= sat31(sn_r);
          out_word_r.last            <= (col_r == n_r - CNT_W'(1));
          out_valid_r                <= 1'b1;
          state_r                    <= S_OUT_HOLD;
        end
        S_OUT_HOLD: begin
          if (!out_stall) begin
            out_valid_r <= 1'b0;
            if (col_r == n_r - CNT_W'(1)) begin
              state_r <= S_IDLE;
            end else begin
              col_r   <= col_r + CNT_W'(1);
              state_r <= S_OUT_RD;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase

      if (ck4_v_r) begin
        sum_rs_r <= sat_addu(sum_rs_r, ck4_rs_r);
        sum_ss_r <= sat_addu(sum_ss_r, ck4_ss_r);
        sum_xs_r <= sat_addu(sum_xs_r, ck4_xs_r);
        sum_zs_r <= sat_addu(sum_zs_r, ck4_zs_r);
        sum_us_r <= sat_addu(sum_us_r, ck4_us_r);
      end
    end
  end

  a_out_only_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_OUT_HOLD))
    else $error("result word shown outside the hold state");

  a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (iter_cnt_r <= cfg_limit_r))
    else $error("iteration count passed the limit");

  a_no_write_in_dot: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_DOT) || (state_r == S_DRAIN)) |-> !v_we)
    else $error("vector store written while the dot product reads it");

  a_last_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_word_r.last && !out_stall) |=> !in_stall)
    else $error("input still stalled after the last result");

endmodule

### src/abp_isqrt.sv
// ----------------------------------------------------------------------------
// abp_isqrt
// floor square root of a 64-bit value, one result bit per cycle
// ----------------------------------------------------------------------------
module abp_isqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] operand,
  output logic        done,
  output logic [31:0] root
);
  logic        busy_r;
  logic        done_r;
  logic [4:0]  cnt_r;
  logic [63:0] val_r;
  logic [34:0] rem_r;
  logic [31:0] root_r;
  logic [34:0] rem_t;
  logic [34:0] trial;

  assign rem_t = {rem_r[32:0], val_r[63:62]};
  assign trial = {1'b0, root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        val_r  <= operand;
        rem_r  <= '0;
        root_r <= '0;
      end else if (busy_r) begin
        val_r <= {val_r[61:0], 2'b00};
        if (rem_t >= trial) begin
          rem_r  <= rem_t - trial;
          root_r <= {root_r[30:0], 1'b1};
        end else begin
          rem_r  <= rem_t;
          root_r <= {root_r[30:0], 1'b0};
        end
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = root_r;
endmodule

### src/abp_recip.sv
// ----------------------------------------------------------------------------
// abp_recip
// shrinkage threshold floor(2^32 / rho), restoring division, saturated
// ----------------------------------------------------------------------------
module abp_recip (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [30:0]        divisor,
  output logic               done,
  output logic signed [31:0] kappa
);
  import abp_pkg::*;

  logic        busy_r;
  logic        done_r;
  logic [5:0]  cnt_r;
  logic [32:0] dvd_r;
  logic [30:0] dsr_r;
  logic [31:0] rem_r;
  logic [32:0] quo_r;
  logic [32:0] rem_t;

  assign rem_t = {rem_r, dvd_r[32]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        dvd_r  <= {1'b1, 32'd0};
        dsr_r  <= divisor;
        rem_r  <= '0;
        quo_r  <= '0;
      end else if (busy_r) begin
        dvd_r <= {dvd_r[31:0], 1'b0};
        if (rem_t >= {2'b00, dsr_r}) begin
          rem_r <= 32'(rem_t - {2'b00, dsr_r});
          quo_r <= {quo_r[31:0], 1'b1};
        end else begin
          rem_r <= rem_t[31:0];
          quo_r <= {quo_r[31:0], 1'b0};
        end
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd32) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done  = done_r;
  assign kappa = (quo_r[32:31] != 2'b00) ? S32_MAX : $signed(quo_r[31:0]);
endmodule

### test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// checks the basis pursuit solver end to end: load and start words go in
// through a queue-fed driver; accepted words and register writes update a
// fixed-point model of the stores and registers, and the monitor compares
// each result field by field with the oldest predicted one, under random idling
// ----------------------------------------------------------------------------
module testbench;
  import abp_pkg::*;

  localparam int  WATCHDOG = 200000;
  localparam longint S_MAX = 64'sd2147483647;
  localparam longint S_MIN = -64'sd2147483648;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_word_t    in_word = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_word_t   out_word;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  admm_basis_pursuit_solver_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  in_word_t  pending_words[$];
  out_word_t expected_words[$];
  int  send_idle = 0;
  int  recv_idle = 0;
  bit  failed = 1'b0;
  int  quiet_cycles = 0;

  // solver state copy
  int mat_st[4096];
  int q_st[64], x_st[64], z_st[64], u_st[64], zo_st[64];
  bit mat_written[4096];
  bit vec_written[64];
  logic [30:0] c_rho = RHO_RST;
  logic [17:0] c_alpha = ALPHA_RST;
  logic [6:0]  c_len = LEN_RST;
  logic        c_chk = 1'b0;
  logic [15:0] c_lim = '0;
  logic [30:0] c_atol = ATOL_RST;
  logic [30:0] c_rtol = RTOL_RST;

  function automatic int s32(input longint v);
    if (v > S_MAX) return 32'sh7FFFFFFF;
    if (v < S_MIN) return 32'sh80000000;
    return int'(v);
  endfunction

  function automatic int fx_product(input int a, input int b);
    return s32((longint'(a) * longint'(b)) >>> 16);
  endfunction

  function automatic int soft_threshold(input int v, input int k);
    longint vv, kk;
    vv = v;
    kk = k;
    if (vv > kk) return s32(vv - kk);
    if (vv < -kk) return s32(vv + kk);
    return 0;
  endfunction

  function automatic logic [63:0] add_sat_u64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  function automatic logic [63:0] square(input int d);
    longint t;
    t = longint'(d) * longint'(d);
    return t;
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] rem, r, b;
    rem = v;
    r = '0;
    b = 64'h1 << 62;
    while (b > rem) b = b >> 2;
    while (b != 0) begin
      if (rem >= r + b) begin
        rem = rem - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic void update_row_tiles(input int n, input int base, input int count,
                                           input int kappa);
    int zu[64];
    int zt[16], ut[16], xt[16];
    int off, i, c, m, r, acc, znew;
    longint a, xh;
    for (off = base; off < base + count; off += 16) begin
      m = base + count - off;
      if (m > 16) m = 16;
      for (c = 0; c < n; c++) zu[c] = s32(longint'(z_st[c]) - z_st[c] + z_st[c] - u_st[c]);
      for (i = 0; i < m; i++) begin
        r = off + i;
        acc = 0;
        for (c = 0; c < n; c++) acc = s32(longint'(acc) + fx_product(mat_st[r*64+c], zu[c]));
        xt[i] = s32(longint'(acc) + q_st[r]);
        zt[i] = z_st[r];
        ut[i] = u_st[r];
      end
      for (i = 0; i < m; i++) begin
        r = off + i;
        a = longint'(c_alpha);
        xh = s32((a * xt[i] + (64'sd65536 - a) * zt[i]) >>> 16);
        znew = soft_threshold(s32(xh + ut[i]), kappa);
        zo_st[r] = zt[i];
        z_st[r] = znew;
        u_st[r] = s32(longint'(ut[i]) + xh - znew);
        x_st[r] = xt[i];
      end
    end
  endfunction

  function automatic void solve_and_queue();
    int n, i, it, done, kappa, dz;
    bit conv;
    logic [63:0] rn, sn, rs, ss, xs, zs, us, xn, zn, un, sqn, bse, ep, ed, k;
    out_word_t w;
    n = c_len;
    if (n > 64) return;
    for (i = 0; i < n; i++) x_st[i] = 0;
    k = 64'h1_0000_0000 / 64'(c_rho);
    kappa = (k > 64'h7FFFFFFF) ? 32'sh7FFFFFFF : int'(k);
    rn = 0;
    sn = 0;
    done = 0;
    conv = 1'b0;
    for (it = 0; it < int'(c_lim); it++) begin
      done++;
      update_row_tiles(n, 0, n / 2, kappa);
      update_row_tiles(n, n / 2, n - n / 2, kappa);
      if (c_chk) begin
        rs = 0; ss = 0; xs = 0; zs = 0; us = 0;
        for (i = 0; i < n; i++) begin
          dz = s32(longint'(z_st[i]) - zo_st[i]);
          rs = add_sat_u64(rs, square(s32(longint'(x_st[i]) - z_st[i])));
          ss = add_sat_u64(ss, square(s32((longint'(c_rho) * dz) >>> 16)));
          xs = add_sat_u64(xs, square(x_st[i]));
          zs = add_sat_u64(zs, square(z_st[i]));
          us = add_sat_u64(us, square(u_st[i]));
        end
        rn = int_sqrt(rs);
        sn = int_sqrt(ss);
        xn = int_sqrt(xs);
        zn = int_sqrt(zs);
        un = (64'(c_rho) * int_sqrt(us)) >> 16;
        if (un > 64'hFFFFFFFF) un = 64'hFFFFFFFF;
        sqn = int_sqrt(64'(n) << 32);
        bse = (sqn * 64'(c_atol)) >> 16;
        ep = bse + ((64'(c_rtol) * ((xn > zn) ? xn : zn)) >> 16);
        ed = bse + ((64'(c_rtol) * un) >> 16);
        if (rn < ep && sn < ed) begin
          conv = 1'b1;
          break;
        end
      end
    end
    for (i = 0; i < n; i++) begin
      w.index = 6'(i);
      w.x_result = x_st[i];
      w.z_result = z_st[i];
      w.u_result = u_st[i];
      w.zold_result = zo_st[i];
      w.iterations_done = 16'(done);
      w.converged = conv;
      w.primal_residual = (rn > 64'h7FFFFFFF) ? '1 : rn[30:0];
      w.dual_residual = (sn > 64'h7FFFFFFF) ? '1 : sn[30:0];
      w.last = (i == n - 1);
      expected_words.push_back(w);
    end
  endfunction

  function automatic void apply_word(input in_word_t w);
    case (w.req_type)
      REQ_LOAD_P: mat_st[int'(w.row)*64 + int'(w.col)] = w.p_value;
      REQ_LOAD_V: begin
        q_st[w.row] = w.q_value;
        z_st[w.row] = w.z_init;
        u_st[w.row] = w.u_init;
        zo_st[w.row] = w.zold_init;
      end
      REQ_START: solve_and_queue();
      default: ;
    endcase
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) apply_word(in_word);
      if (!(in_valid && in_stall)) begin
        if (pending_words.size() > 0 && $urandom_range(99) >= send_idle) begin
          in_valid <= 1'b1;
          in_word <= pending_words.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    out_word_t e;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          $error("unexpected result word index %0d", out_word.index);
          failed = 1'b1;
        end else begin
          e = expected_words.pop_front();
          if (out_word.index !== e.index) begin
            $error("index: expected %0d actual %0d", e.index, out_word.index);
            failed = 1'b1;
          end
          if (out_word.x_result !== e.x_result) begin
            $error("x_result: expected %0d actual %0d", e.x_result, out_word.x_result);
            failed = 1'b1;
          end
          if (out_word.z_result !== e.z_result) begin
            $error("z_result: expected %0d actual %0d", e.z_result, out_word.z_result);
            failed = 1'b1;
          end
          if (out_word.u_result !== e.u_result) begin
            $error("u_result: expected %0d actual %0d", e.u_result, out_word.u_result);
            failed = 1'b1;
          end
          if (out_word.zold_result !== e.zold_result) begin
            $error("zold_result: expected %0d actual %0d", e.zold_result,
                   out_word.zold_result);
            failed = 1'b1;
          end
          if (out_word.iterations_done !== e.iterations_done) begin
            $error("iterations_done: expected %0d actual %0d", e.iterations_done,
                   out_word.iterations_done);
            failed = 1'b1;
          end
          if (out_word.converged !== e.converged) begin
            $error("converged: expected %0d actual %0d", e.converged, out_word.converged);
            failed = 1'b1;
          end
          if (out_word.primal_residual !== e.primal_residual) begin
            $error("primal_residual: expected %0d actual %0d", e.primal_residual,
                   out_word.primal_residual);
            failed = 1'b1;
          end
          if (out_word.dual_residual !== e.dual_residual) begin
            $error("dual_residual: expected %0d actual %0d", e.dual_residual,
                   out_word.dual_residual);
            failed = 1'b1;
          end
          if (out_word.last !== e.last) begin
            $error("last: expected %0d actual %0d", e.last, out_word.last);
            failed = 1'b1;
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG) begin
        $display("** admm_basis_pursuit_solver_top: FAILED **");
        $finish;
      end
    end
  end

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2, 3: return 32'($urandom_range(0, 32'h80000)) - 32'h40000;
      default: return $urandom;
    endcase
  endfunction

  function automatic in_word_t rand_word(input logic [1:0] kind);
    in_word_t w;
    w.req_type = kind;
    w.row = 6'($urandom);
    w.col = 6'($urandom);
    w.p_value = pick_value();
    w.q_value = pick_value();
    w.z_init = pick_value();
    w.u_init = pick_value();
    w.zold_init = pick_value();
    return w;
  endfunction

  task automatic push_matrix(input int r, input int c, input logic [31:0] v);
    in_word_t w;
    w = rand_word(REQ_LOAD_P);
    w.row = 6'(r);
    w.col = 6'(c);
    w.p_value = v;
    mat_written[r*64 + c] = 1'b1;
    pending_words.push_back(w);
  endtask

  task automatic push_vector(input int r, input bit zero);
    in_word_t w;
    w = rand_word(REQ_LOAD_V);
    w.row = 6'(r);
    if (zero) begin
      w.q_value = '0;
      w.z_init = '0;
      w.u_init = '0;
      w.zold_init = '0;
    end
    vec_written[r] = 1'b1;
    pending_words.push_back(w);
  endtask

  task automatic fill_unwritten(input int n);
    int r, c;
    for (r = 0; r < n; r++) begin
      for (c = 0; c < n; c++) if (!mat_written[r*64 + c]) push_matrix(r, c, pick_value());
      if (!vec_written[r]) push_vector(r, 1'b0);
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_RHO:   c_rho = val[30:0];
      REG_ALPHA: c_alpha = val[17:0];
      REG_LEN:   c_len = val[6:0];
      REG_CHK:   c_chk = val[0];
      REG_LIMIT: c_lim = val[15:0];
      REG_ATOL:  c_atol = val[30:0];
      REG_RTOL:  c_rtol = val[30:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_words.size() != 0 || in_valid || expected_words.size() != 0 || in_stall)
      @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic set_regs(input int n, input int lim, input bit chk, input logic [30:0] rho,
                          input logic [17:0] alp, input logic [30:0] atol,
                          input logic [30:0] rtol);
    drain();
    write_reg(REG_RHO, 32'(rho));
    write_reg(REG_ALPHA, 32'(alp));
    write_reg(REG_LEN, 32'(n));
    write_reg(REG_CHK, 32'(chk));
    write_reg(REG_LIMIT, 32'(lim));
    write_reg(REG_ATOL, 32'(atol));
    write_reg(REG_RTOL, 32'(rtol));
  endtask

  task automatic queue_solves(input int n, input int nst, input bit zero_vec);
    int s, j, nb;
    nb = (n > 64) ? 0 : n;
    for (s = 0; s < nst; s++) begin
      if (zero_vec) begin
        for (j = 0; j < nb; j++) push_vector(j, 1'b1);
      end else if (nb > 0) begin
        repeat ($urandom_range(0, 5)) begin
          if ($urandom_range(0, 1)) push_matrix($urandom_range(0, nb-1),
                                                $urandom_range(0, nb-1), pick_value());
          else push_vector($urandom_range(0, nb-1), 1'b0);
        end
      end
      if ($urandom_range(0, 5) == 0) pending_words.push_back(rand_word(2'd3));
      fill_unwritten(nb);
      pending_words.push_back(rand_word(REQ_START));
    end
  endtask

  function automatic logic [30:0] pick_rho();
    case ($urandom_range(0, 4))
      0: return 31'd1;
      1: return 31'h7FFFFFFF;
      2: return 31'($urandom_range(16384, 262144));
      3: return 31'd65536;
      default: return 31'($urandom) | 31'd1;
    endcase
  endfunction

  function automatic logic [17:0] pick_alpha();
    case ($urandom_range(0, 3))
      0: return 18'd0;
      1: return 18'd131072;
      default: return 18'($urandom_range(0, 131072));
    endcase
  endfunction

  function automatic logic [30:0] pick_tol();
    case ($urandom_range(0, 4))
      0: return 31'd0;
      1: return 31'h7FFFFFFF;
      2: return 31'($urandom_range(0, 2000));
      default: return 31'($urandom_range(0, 32'h100000));
    endcase
  endfunction

  task automatic random_phase();
    int n;
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
    set_regs(n, $urandom_range(0, 5), 1'($urandom), pick_rho(), pick_alpha(),
             pick_tol(), pick_tol());
    queue_solves(n, 3, 1'b0);
  endtask

  initial begin
    in_word_t w;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    send_idle = 14;
    recv_idle = 54;
    set_regs(4, 2, 1'b1, 31'd65536, 18'd65536, 31'd7, 31'd655);
    push_matrix(0, 0, 32'h7FFFFFFF);
    push_matrix(3, 3, 32'h80000000);
    push_matrix(63, 63, 32'h80000000);
    push_vector(63, 1'b0);
    w = rand_word(REQ_LOAD_V);
    w.row = 6'd1;
    w.q_value = 32'h7FFFFFFF;
    w.z_init = 32'h80000000;
    w.u_init = 32'h7FFFFFFF;
    w.zold_init = 32'h80000000;
    vec_written[1] = 1'b1;
    pending_words.push_back(w);
    pending_words.push_back(rand_word(2'd3));
    fill_unwritten(4);
    pending_words.push_back(rand_word(REQ_START));

    // empty, oversized, zero-iteration and extreme-parameter starts
    set_regs(0, 2, 1'b1, 31'd65536, 18'd65536, 31'd7, 31'd655);
    queue_solves(0, 1, 1'b0);
    set_regs(100, 1, 1'b0, 31'd65536, 18'd65536, 31'd7, 31'd655);
    queue_solves(100, 1, 1'b0);
    set_regs(127, 1, 1'b0, 31'd65536, 18'd65536, 31'd7, 31'd655);
    queue_solves(127, 1, 1'b0);
    set_regs(3, 0, 1'b1, 31'd65536, 18'd65536, 31'd7, 31'd655);
    queue_solves(3, 1, 1'b0);
    set_regs(3, 3, 1'b1, 31'd1, 18'd0, 31'd0, 31'd0);
    queue_solves(3, 1, 1'b0);
    set_regs(5, 3, 1'b1, 31'h7FFFFFFF, 18'd131072, 31'h7FFFFFFF, 31'h7FFFFFFF);
    queue_solves(5, 1, 1'b0);
    // zero vector data converges on the first pass even with the largest limit
    set_regs(2, 65535, 1'b1, 31'd65536, 18'd65536, 31'h7FFFFFFF, 31'h7FFFFFFF);
    queue_solves(2, 1, 1'b1);

    repeat (8) random_phase();
    send_idle = 54;
    recv_idle = 14;
    repeat (8) random_phase();
    set_regs(33, 2, 1'b1, pick_rho(), pick_alpha(), pick_tol(), pick_tol());
    queue_solves(33, 1, 1'b0);
    send_idle = 0;
    recv_idle = 0;
    repeat (8) random_phase();
    set_regs(64, 1, 1'b1, 31'd65536, 18'd65536, 31'd7, 31'd655);
    queue_solves(64, 1, 1'b0);

    drain();
    repeat (400) @(posedge clk);
    if (!failed && expected_words.size() == 0) begin
      $display("** admm_basis_pursuit_solver_top: PASSED **");
    end else begin
      $display("** admm_basis_pursuit_solver_top: FAILED **");
    end
    $finish;
  end

endmodule
